// ===== design/ham6_pixel_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// HAM6 pixel encoder assertion macros
// Shared assertion macros for the encoder. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef HAM6_PIXEL_ENCODER_DEFINES_SVH
`define HAM6_PIXEL_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define HAM6_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define HAM6_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/ham6_pkg.sv =====
// ----------------------------------------------------------------------------
// HAM6 pixel encoder package
// Types, constants and helper functions shared across the encoder.
// ----------------------------------------------------------------------------
package ham6_pkg;

  // Default and largest palette size.
  localparam int PALETTE_DEPTH_DEF = 16;

  // Field widths fixed by the pixel and pen formats.
  localparam int PIX_W  = 8;
  localparam int CH_W   = 4;
  localparam int DIST_W = 6;
  localparam int PEN_W  = 6;
  localparam int LIMIT_W = 5;
  localparam int CFG_W  = 6;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LIMIT   = 1'b1;

  // Configuration reset values.
  localparam logic [DIST_W-1:0]  THRESHOLD_RESET = 6'd4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 5'd16;

  // Distance start value for a search; above any real distance (at most 45).
  localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

  // Division by 17 as a multiply by a reciprocal: exact for 8-bit inputs.
  localparam int QUANT_MUL   = 241;
  localparam int QUANT_SHIFT = 12;

  // A 12-bit colour, four bits a channel.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } colour_t;

  localparam colour_t COLOUR_BLACK = '{red: 4'd0, green: 4'd0, blue: 4'd0};
  localparam colour_t COLOUR_WHITE = '{red: 4'd15, green: 4'd15, blue: 4'd15};

  // Channel select, encoded as the top two bits of the modify pen.
  typedef enum logic [1:0] {
    CH_BLUE  = 2'b01,
    CH_RED   = 2'b10,
    CH_GREEN = 2'b11
  } chan_sel_t;

  // Result of the shared distance unit.
  typedef struct packed {
    logic [DIST_W-1:0] full;
    logic [DIST_W-1:0] corrected;
    chan_sel_t         worst;
  } dist_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SEARCH,
    S_ALLOC,
    S_EMIT
  } state_t;

  // Quantise an 8-bit channel to 4 bits (value / 17).
  function automatic logic [CH_W-1:0] quantise(input logic [PIX_W-1:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'(QUANT_MUL);
    return prod[15:QUANT_SHIFT];
  endfunction

endpackage

// ===== design/ham6_if.sv =====
// ----------------------------------------------------------------------------
// HAM6 pixel encoder channel interfaces
// Valid/ready channels for incoming pixels and outgoing pen codes.
// ----------------------------------------------------------------------------
interface ham6_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       line_start;

  modport source (output valid, red_in, green_in, blue_in, line_start, input ready);
  modport sink (input valid, red_in, green_in, blue_in, line_start, output ready);
endinterface

interface ham6_pen_if;
  logic       valid;
  logic       ready;
  logic [5:0] pen;
  logic       alloc_valid;
  logic [3:0] alloc_index;
  logic [3:0] alloc_red;
  logic [3:0] alloc_green;
  logic [3:0] alloc_blue;

  modport source (output valid, pen, alloc_valid, alloc_index, alloc_red, alloc_green,
                  alloc_blue, input ready);
  modport sink (input valid, pen, alloc_valid, alloc_index, alloc_red, alloc_green,
                alloc_blue, output ready);
endinterface

// ===== design/ham6_pixel_encoder.sv =====
// ----------------------------------------------------------------------------
// HAM6 pixel encoder
// Turns 8-bit RGB pixels into 6-bit hold-and-modify pen codes.
// ----------------------------------------------------------------------------
// One pixel is taken at a time and is quantised as it is transferred. The
// sequencer then compares it with the previous colour in S_PREP and, when a
// palette search is needed, visits each palette entry in use (2 up to
// PALETTE_DEPTH) in S_SEARCH, then passes through S_ALLOC and S_EMIT, which
// hands over the result once the output register is free. The search is
// skipped when the pixel does not start a line and the previous colour
// already matches in at least two channels. The search shares the single
// distance unit across the entries. A result may wait in the output
// register while the next pixel is taken in. Configuration writes are
// taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
`include "ham6_pixel_encoder_defines.svh"

module ham6_pixel_encoder #(
  parameter int PALETTE_DEPTH = ham6_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ham6_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ham6_pkg::CFG_W-1:0]       cfg_data,
  ham6_pixel_if.sink                       pixel,
  ham6_pen_if.source                       code
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  ham6_pkg::state_t            state, state_next;
  ham6_pkg::colour_t           q;
  ham6_pkg::colour_t           prev;
  ham6_pkg::colour_t           modified;
  ham6_pkg::colour_t           dist_b;
  ham6_pkg::colour_t           rd_data;
  ham6_pkg::dist_t             dres;
  ham6_pkg::chan_sel_t         widx;
  logic                        ls;
  logic [ham6_pkg::DIST_W-1:0] dif;
  logic [ham6_pkg::DIST_W-1:0] bestd;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            best;
  logic [IDX_W-1:0]            rd_addr;
  logic [CNT_W-1:0]            used;
  logic [ham6_pkg::DIST_W-1:0] threshold;
  logic [ham6_pkg::LIMIT_W-1:0] limit;
  logic [ham6_pkg::LIMIT_W-1:0] cap;
  logic                        alloc;
  logic                        use_pal;
  logic                        do_alloc;
  logic                        last_entry;
  logic                        emit_go;
  logic [ham6_pkg::CH_W-1:0]   mod_val;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ham6_pkg::THRESHOLD_RESET;
      limit     <= ham6_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ham6_pkg::CFG_ALLOC_THRESHOLD: threshold <= cfg_data;
        ham6_pkg::CFG_PALETTE_LIMIT:   limit     <= cfg_data[ham6_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  // Palette store.
  ham6_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (state == ham6_pkg::S_ALLOC && do_alloc),
    .wr_addr (used[IDX_W-1:0]),
    .wr_data (q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared distance unit: previous colour first, palette entries after.
  assign dist_b  = (state == ham6_pkg::S_PREP) ? prev : rd_data;
  assign rd_addr = (state == ham6_pkg::S_EMIT) ? best : idx;

  ham6_dist_unit u_dist (
    .a      (q),
    .b      (dist_b),
    .result (dres)
  );

  // Allocation test: a value of palette_limit above the depth acts as the depth.
  always_comb begin
    cap = (limit < ham6_pkg::LIMIT_W'(PALETTE_DEPTH)) ? limit
                                                       : ham6_pkg::LIMIT_W'(PALETTE_DEPTH);
    do_alloc   = (bestd > threshold) && (ham6_pkg::LIMIT_W'(used) < cap);
    last_entry = (CNT_W'(idx) + CNT_W'(1)) == used;
    emit_go    = (state == ham6_pkg::S_EMIT) && (!code.valid || code.ready);
  end

  // Modify path: the worst channel takes its quantised value.
  always_comb begin
    modified = prev;
    case (widx)
      ham6_pkg::CH_GREEN: begin
        mod_val        = q.green;
        modified.green = q.green;
      end
      ham6_pkg::CH_BLUE: begin
        mod_val       = q.blue;
        modified.blue = q.blue;
      end
      default: begin
        mod_val      = q.red;
        modified.red = q.red;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ham6_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and pixel handshake.
  always_comb begin
    state_next  = state;
    pixel.ready = 1'b0;
    unique case (state)
      ham6_pkg::S_IDLE: begin
        pixel.ready = 1'b1;
        if (pixel.valid) state_next = ham6_pkg::S_PREP;
      end
      ham6_pkg::S_PREP: begin
        if (!ls && dres.corrected == '0) state_next = ham6_pkg::S_EMIT;
        else state_next = ham6_pkg::S_SEARCH;
      end
      ham6_pkg::S_SEARCH: begin
        if (last_entry) state_next = ham6_pkg::S_ALLOC;
      end
      ham6_pkg::S_ALLOC: begin
        state_next = ham6_pkg::S_EMIT;
      end
      ham6_pkg::S_EMIT: begin
        if (emit_go) state_next = ham6_pkg::S_IDLE;
      end
      default: state_next = ham6_pkg::S_IDLE;
    endcase
  end

  // Per-pixel working registers.
  always_ff @(posedge clk) begin
    if (state == ham6_pkg::S_IDLE && pixel.valid) begin
      q.red   <= ham6_pkg::quantise(pixel.red_in);
      q.green <= ham6_pkg::quantise(pixel.green_in);
      q.blue  <= ham6_pkg::quantise(pixel.blue_in);
      ls      <= pixel.line_start;
    end
    if (state == ham6_pkg::S_PREP) begin
      dif     <= dres.corrected;
      widx    <= dres.worst;
      idx     <= '0;
      best    <= '0;
      bestd   <= ham6_pkg::DIST_MAX;
      alloc   <= 1'b0;
      use_pal <= 1'b0;
    end
    if (state == ham6_pkg::S_SEARCH) begin
      if (dres.full < bestd) begin
        bestd <= dres.full;
        best  <= idx;
      end
      idx <= idx + IDX_W'(1);
    end
    if (state == ham6_pkg::S_ALLOC) begin
      if (do_alloc) begin
        best  <= used[IDX_W-1:0];
        bestd <= '0;
        alloc <= 1'b1;
      end
      use_pal <= ls || ((do_alloc ? '0 : bestd) < dif);
    end
  end

  // Palette fill count and previous colour.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= CNT_W'(2);
      prev <= ham6_pkg::COLOUR_BLACK;
    end else begin
      if (state == ham6_pkg::S_ALLOC && do_alloc) used <= used + CNT_W'(1);
      if (emit_go) prev <= use_pal ? rd_data : modified;
    end
  end

  // Output register; a result may wait here while the next pixel is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      code.valid <= 1'b0;
    end else if (emit_go) begin
      code.valid <= 1'b1;
    end else if (code.ready) begin
      code.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      code.pen         <= use_pal ? ham6_pkg::PEN_W'(best) : {widx, mod_val};
      code.alloc_valid <= alloc;
      code.alloc_index <= alloc ? 4'(best) : 4'd0;
      code.alloc_red   <= alloc ? q.red   : 4'd0;
      code.alloc_green <= alloc ? q.green : 4'd0;
      code.alloc_blue  <= alloc ? q.blue  : 4'd0;
    end
  end

  // Assertions.
  `HAM6_ASSERT_ALWAYS(a_used_range,
    used >= CNT_W'(2) && used <= CNT_W'(PALETTE_DEPTH), "palette fill count out of range")
  `HAM6_ASSERT_ALWAYS(a_search_bound,
    state != ham6_pkg::S_SEARCH || CNT_W'(idx) < used, "search index beyond filled entries")
  `HAM6_ASSERT_NEXT(a_alloc_count, state == ham6_pkg::S_ALLOC && do_alloc,
    used == $past(used) + CNT_W'(1), "allocation did not advance fill count")
  `HAM6_ASSERT_NEXT(a_alloc_index, emit_go && alloc,
    code.alloc_index == 4'(used - CNT_W'(1)), "allocated index is not the newest entry")

endmodule

// ===== design/ham6_dist_unit.sv =====
// ----------------------------------------------------------------------------
// HAM6 distance unit
// Shared colour distance: full sum, sum less the worst channel, worst channel.
// ----------------------------------------------------------------------------
module ham6_dist_unit (
  input  ham6_pkg::colour_t a,
  input  ham6_pkg::colour_t b,
  output ham6_pkg::dist_t   result
);

  logic [ham6_pkg::CH_W-1:0]   d_red, d_green, d_blue;
  logic [ham6_pkg::CH_W-1:0]   worst_val;
  logic [ham6_pkg::DIST_W-1:0] sum;

  // Absolute difference on each channel.
  always_comb begin
    d_red   = (a.red   > b.red)   ? a.red   - b.red   : b.red   - a.red;
    d_green = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    d_blue  = (a.blue  > b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
  end

  // Worst channel; ties keep the earlier channel, red first.
  always_comb begin
    worst_val    = d_red;
    result.worst = ham6_pkg::CH_RED;
    if (d_green > worst_val) begin
      worst_val    = d_green;
      result.worst = ham6_pkg::CH_GREEN;
    end
    if (d_blue > worst_val) begin
      worst_val    = d_blue;
      result.worst = ham6_pkg::CH_BLUE;
    end
  end

  // Sum of the differences and the corrected distance.
  always_comb begin
    sum              = ham6_pkg::DIST_W'(d_red) + ham6_pkg::DIST_W'(d_green)
                     + ham6_pkg::DIST_W'(d_blue);
    result.full      = sum;
    result.corrected = sum - ham6_pkg::DIST_W'(worst_val);
  end

endmodule

// ===== design/ham6_palette.sv =====
// ----------------------------------------------------------------------------
// HAM6 palette store
// Colour registers with one write port and one read port.
// ----------------------------------------------------------------------------
module ham6_palette #(
  parameter int DEPTH = ham6_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ham6_pkg::colour_t        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ham6_pkg::colour_t        rd_data
);

  ham6_pkg::colour_t entries [DEPTH];

  // Entry 1 resets to white and all others to black.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        entries[k] <= (k == 1) ? ham6_pkg::COLOUR_WHITE : ham6_pkg::COLOUR_BLACK;
      end
    end else if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
  end

  // Read port.
  assign rd_data = entries[rd_addr];

endmodule
